FILE: rtl/core/row_sum_merge_sorter_defines.svh
// Assertion macros shared by the row-sum merge sorter RTL.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef ROW_SUM_MERGE_SORTER_DEFINES_SVH
`define ROW_SUM_MERGE_SORTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RSMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RSMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rsms_pkg.sv
// Package for the row-sum merge sorter: payload structs, state enums, codes.
// No dependencies.
package rsms_pkg;

  localparam int DATA_W  = 32;
  localparam int CFG_W   = 5;
  localparam int PADDR_W = 3;

  // register index (taken from paddr[2])
  localparam logic REG_COLS = 1'b0;

  // input item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] value;
    logic                     last_load;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value_res;
    logic                     row_end;
    logic                     all_done;
    logic                     dropped;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FILL, ST_SORT, ST_DIV, ST_FORD, ST_FIDX, ST_FELEM, ST_FOUT
  } top_state_t;

  typedef enum logic [3:0] {
    SS_IDLE, SS_INIT, SS_PASS, SS_RUN, SS_STEP, SS_IDX, SS_SUM, SS_ELEM, SS_TAKE,
    SS_COPY
  } sort_state_t;

  // sequencer status towards the control block
  typedef struct packed {
    logic busy;
    logic done;
    logic bank;
  } sort_stat_t;

endpackage

FILE: rtl/core/rsms_mem.sv
// Synchronous memory, one write port and two registered read ports.
// No dependencies.
module rsms_mem #(
  parameter int DW    = 32,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a_r,
  output logic [DW-1:0] rdata_b_r
);

  logic [DW-1:0] mem_r [DEPTH];

  // write and read, read data valid in the next cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

endmodule

FILE: rtl/core/rsms_sort.sv
// Bottom-up stable merge sort sequencer over the order buffer memory.
// Depends on rsms_pkg; drives read ports of the sum and element memories.
module rsms_sort import rsms_pkg::*; #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 16,
  localparam int ROW_W   = $clog2(MAX_ROWS),
  localparam int RC_W    = $clog2(MAX_ROWS + 1),
  localparam int EC_W    = $clog2(MAX_COLS + 1),
  localparam int SUM_W   = DATA_W + $clog2(MAX_COLS),
  localparam int ORD_AW  = $clog2(2 * MAX_ROWS),
  localparam int ELEM_AW = $clog2(MAX_ROWS * MAX_COLS)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [RC_W-1:0]          n,
  input  logic [EC_W-1:0]          cols,
  output sort_stat_t               stat,
  output logic                     ord_we,
  output logic [ORD_AW-1:0]        ord_waddr,
  output logic [ROW_W-1:0]         ord_wdata,
  output logic [ORD_AW-1:0]        ord_raddr_a,
  output logic [ORD_AW-1:0]        ord_raddr_b,
  input  logic [ROW_W-1:0]         ord_rdata_a,
  input  logic [ROW_W-1:0]         ord_rdata_b,
  output logic [ROW_W-1:0]         sum_raddr_a,
  output logic [ROW_W-1:0]         sum_raddr_b,
  input  logic signed [SUM_W-1:0]  sum_rdata_a,
  input  logic signed [SUM_W-1:0]  sum_rdata_b,
  output logic [ELEM_AW-1:0]       elem_raddr_a,
  output logic [ELEM_AW-1:0]       elem_raddr_b,
  input  logic signed [DATA_W-1:0] elem_rdata_a,
  input  logic signed [DATA_W-1:0] elem_rdata_b
);

  localparam int CNT_W = $clog2(MAX_ROWS) + 2;

  sort_state_t      st_r, st_nxt;
  logic [CNT_W-1:0] n_r, n_nxt, width_r, width_nxt, lo_r, lo_nxt;
  logic [CNT_W-1:0] mid_r, mid_nxt, hi_r, hi_nxt;
  logic [CNT_W-1:0] l_r, l_nxt, r_r, r_nxt, o_r, o_nxt;
  logic [CNT_W-1:0] sum_lw, sum_lww;
  logic             src_r, src_nxt, take_r, take_nxt, copyl_r, copyl_nxt;
  logic [ROW_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [EC_W-1:0]  c_r, c_nxt, c_inc;

  function automatic logic [ORD_AW-1:0] oaddr(input logic bank, input int idx);
    int t;
    t = idx + (bank ? MAX_ROWS : 0);
    return ORD_AW'(t);
  endfunction

  function automatic logic [ELEM_AW-1:0] eaddr(input int row, input int col);
    int t;
    t = row * MAX_COLS + col;
    return ELEM_AW'(t);
  endfunction

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= SS_IDLE;
      src_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      src_r <= src_nxt;
    end
  end

  // merge bookkeeping
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    width_r <= width_nxt;
    lo_r    <= lo_nxt;
    mid_r   <= mid_nxt;
    hi_r    <= hi_nxt;
    l_r     <= l_nxt;
    r_r     <= r_nxt;
    o_r     <= o_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    c_r     <= c_nxt;
    take_r  <= take_nxt;
    copyl_r <= copyl_nxt;
  end

  assign sum_lw  = lo_r + width_r;
  assign sum_lww = lo_r + (width_r << 1);
  assign c_inc   = c_r + 1'b1;

  // next state and memory requests
  always_comb begin
    st_nxt       = st_r;
    n_nxt        = n_r;
    width_nxt    = width_r;
    lo_nxt       = lo_r;
    mid_nxt      = mid_r;
    hi_nxt       = hi_r;
    l_nxt        = l_r;
    r_nxt        = r_r;
    o_nxt        = o_r;
    src_nxt      = src_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    c_nxt        = c_r;
    take_nxt     = take_r;
    copyl_nxt    = copyl_r;
    stat.busy    = (st_r != SS_IDLE);
    stat.done    = 1'b0;
    stat.bank    = src_r;
    ord_we       = 1'b0;
    ord_waddr    = '0;
    ord_wdata    = '0;
    ord_raddr_a  = '0;
    ord_raddr_b  = '0;
    sum_raddr_a  = '0;
    sum_raddr_b  = '0;
    elem_raddr_a = '0;
    elem_raddr_b = '0;
    case (st_r)
      SS_IDLE: begin
        if (start) begin
          n_nxt   = CNT_W'(n);
          o_nxt   = '0;
          src_nxt = 1'b0;
          st_nxt  = SS_INIT;
        end
      end
      // identity order into bank 0
      SS_INIT: begin
        if (o_r < n_r) begin
          ord_we    = 1'b1;
          ord_waddr = oaddr(1'b0, int'(o_r));
          ord_wdata = ROW_W'(o_r);
          o_nxt     = o_r + 1'b1;
        end else begin
          width_nxt = CNT_W'(1);
          st_nxt    = SS_PASS;
        end
      end
      SS_PASS: begin
        if (width_r >= n_r) begin
          stat.done = 1'b1;
          st_nxt    = SS_IDLE;
        end else begin
          lo_nxt = '0;
          st_nxt = SS_RUN;
        end
      end
      // set up one pair of runs
      SS_RUN: begin
        if (lo_r >= n_r) begin
          width_nxt = width_r << 1;
          src_nxt   = ~src_r;
          st_nxt    = SS_PASS;
        end else begin
          mid_nxt = (sum_lw < n_r) ? sum_lw : n_r;
          hi_nxt  = (sum_lww < n_r) ? sum_lww : n_r;
          l_nxt   = lo_r;
          r_nxt   = (sum_lw < n_r) ? sum_lw : n_r;
          o_nxt   = lo_r;
          st_nxt  = SS_STEP;
        end
      end
      SS_STEP: begin
        if (l_r < mid_r && r_r < hi_r) begin
          ord_raddr_a = oaddr(src_r, int'(l_r));
          ord_raddr_b = oaddr(src_r, int'(r_r));
          st_nxt      = SS_IDX;
        end else if (l_r < mid_r) begin
          ord_raddr_a = oaddr(src_r, int'(l_r));
          copyl_nxt   = 1'b1;
          st_nxt      = SS_COPY;
        end else if (r_r < hi_r) begin
          ord_raddr_a = oaddr(src_r, int'(r_r));
          copyl_nxt   = 1'b0;
          st_nxt      = SS_COPY;
        end else begin
          lo_nxt = hi_r;
          st_nxt = SS_RUN;
        end
      end
      SS_IDX: begin
        a_nxt       = ord_rdata_a;
        b_nxt       = ord_rdata_b;
        sum_raddr_a = ord_rdata_a;
        sum_raddr_b = ord_rdata_b;
        st_nxt      = SS_SUM;
      end
      // larger sum first
      SS_SUM: begin
        if (sum_rdata_a != sum_rdata_b) begin
          take_nxt = (sum_rdata_a > sum_rdata_b);
          st_nxt   = SS_TAKE;
        end else begin
          c_nxt        = '0;
          elem_raddr_a = eaddr(int'(a_r), 0);
          elem_raddr_b = eaddr(int'(b_r), 0);
          st_nxt       = SS_ELEM;
        end
      end
      // tie: ascending element order, left wins full ties
      SS_ELEM: begin
        if (elem_rdata_a != elem_rdata_b) begin
          take_nxt = (elem_rdata_a < elem_rdata_b);
          st_nxt   = SS_TAKE;
        end else if (c_inc >= cols) begin
          take_nxt = 1'b1;
          st_nxt   = SS_TAKE;
        end else begin
          c_nxt        = c_inc;
          elem_raddr_a = eaddr(int'(a_r), int'(c_inc));
          elem_raddr_b = eaddr(int'(b_r), int'(c_inc));
        end
      end
      SS_TAKE: begin
        ord_we    = 1'b1;
        ord_waddr = oaddr(~src_r, int'(o_r));
        ord_wdata = take_r ? a_r : b_r;
        o_nxt     = o_r + 1'b1;
        if (take_r) begin
          l_nxt = l_r + 1'b1;
        end else begin
          r_nxt = r_r + 1'b1;
        end
        st_nxt = SS_STEP;
      end
      // one run exhausted, copy the other
      SS_COPY: begin
        ord_we    = 1'b1;
        ord_waddr = oaddr(~src_r, int'(o_r));
        ord_wdata = ord_rdata_a;
        o_nxt     = o_r + 1'b1;
        if (copyl_r) begin
          l_nxt = l_r + 1'b1;
        end else begin
          r_nxt = r_r + 1'b1;
        end
        st_nxt = SS_STEP;
      end
      default: begin
        st_nxt = SS_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/row_sum_merge_sorter.sv
// Row-sum merge sorter top level: load/fetch control, config port, memories.
// Depends on rsms_pkg, rsms_mem, rsms_sort and the assertion macro header.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | in_item_t (mode, value, last_load)
//  out_    | output    | out_valid/out_stall | out_item_t (value_res, flags)
//  cfg     | input     | psel/penable/pready | cols_in_use at paddr 0
//
// A load is accepted only while idle; the load marked last zero-fills the rest of a
// partial row. The sort first writes the identity order; a merge step reads two order
// indices, then their row sums, compares elements column by column on equal sums and
// writes one index; a copied index is read and written. A fetch runs through the order
// and element memory reads; after a config write the first fetch adds an iterative
// divide of the position by the row length. Synchronous active-low reset; memories are
// not cleared. A held result stalls the fetch in its last step; loads stall meanwhile.
`include "row_sum_merge_sorter_defines.svh"

module row_sum_merge_sorter import rsms_pkg::*; #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int RC_W    = $clog2(MAX_ROWS + 1);
  localparam int EC_W    = $clog2(MAX_COLS + 1);
  localparam int SUM_W   = DATA_W + $clog2(MAX_COLS);
  localparam int ORD_AW  = $clog2(2 * MAX_ROWS);
  localparam int ELEM_AW = $clog2(MAX_ROWS * MAX_COLS);
  localparam int POS_W   = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int DC_W    = $clog2(POS_W + 1);

  top_state_t        st_r, st_nxt;
  logic [CFG_W-1:0]  cols_r, cols_nxt;
  logic [RC_W-1:0]   row_cnt_r, row_cnt_nxt, rd_row_r, rd_row_nxt;
  logic [EC_W-1:0]   col_cnt_r, col_cnt_nxt, rd_col_r, rd_col_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt, quo_r, quo_nxt, total;
  logic [EC_W:0]     rem_r, rem_nxt, rem_sh;
  logic [DC_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic              sorted_r, sorted_nxt, ovf_r, ovf_nxt, bank_r, bank_nxt;
  logic              recalc_r, recalc_nxt, out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0] acc_r, acc_nxt, sum_new;
  logic [ROW_W-1:0]  fetch_row_r, fetch_row_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic [EC_W-1:0]   eff, cc0, cc1, cc2;
  logic [RC_W-1:0]   rc0, rc1;
  logic              ovf1, accept, cfg_wr, sort_start;
  logic signed [DATA_W-1:0] v;

  // memory ports
  logic                     elem_we;
  logic [ELEM_AW-1:0]       elem_waddr, elem_raddr_a, s_elem_raddr_a, s_elem_raddr_b;
  logic signed [DATA_W-1:0] elem_wdata, elem_rdata_a, elem_rdata_b;
  logic                     sum_we;
  logic [ROW_W-1:0]         sum_waddr, s_sum_raddr_a, s_sum_raddr_b;
  logic signed [SUM_W-1:0]  sum_rdata_a, sum_rdata_b;
  logic                     s_ord_we;
  logic [ORD_AW-1:0]        s_ord_waddr, s_ord_raddr_a, s_ord_raddr_b, ord_raddr_a;
  logic [ROW_W-1:0]         s_ord_wdata, ord_rdata_a, ord_rdata_b;
  sort_stat_t               sort_stat;

  function automatic logic [ORD_AW-1:0] oaddr(input logic bank, input int idx);
    int t;
    t = idx + (bank ? MAX_ROWS : 0);
    return ORD_AW'(t);
  endfunction

  function automatic logic [ELEM_AW-1:0] eaddr(input int row, input int col);
    int t;
    t = row * MAX_COLS + col;
    return ELEM_AW'(t);
  endfunction

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_COLS);
  assign prdata = (paddr[2] == REG_COLS) ? DATA_W'(cols_r) : '0;
  assign cols_nxt = cfg_wr ? pwdata[CFG_W-1:0] : cols_r;

  // effective row length: zero acts as one, clipped at MAX_COLS
  always_comb begin
    if (cols_r == '0) begin
      eff = EC_W'(1);
    end else if (int'(cols_r) > MAX_COLS) begin
      eff = EC_W'(MAX_COLS);
    end else begin
      eff = EC_W'(cols_r);
    end
  end

  assign total     = POS_W'(int'(row_cnt_r) * int'(eff));
  assign in_stall  = (st_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign v         = in_data.value;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign rem_sh    = {rem_r[EC_W-1:0], quo_r[POS_W-1]};

  // memories
  assign elem_raddr_a = sort_stat.busy ? s_elem_raddr_a
                                       : eaddr(int'(fetch_row_r), int'(rd_col_r));
  assign ord_raddr_a  = sort_stat.busy ? s_ord_raddr_a
                                       : oaddr(bank_r, int'(rd_row_r));

  rsms_mem #(.DW(DATA_W), .DEPTH(MAX_ROWS * MAX_COLS)) u_elem (
    .clk(clk), .we(elem_we), .waddr(elem_waddr), .wdata(elem_wdata),
    .raddr_a(elem_raddr_a), .raddr_b(s_elem_raddr_b),
    .rdata_a_r(elem_rdata_a), .rdata_b_r(elem_rdata_b)
  );

  rsms_mem #(.DW(SUM_W), .DEPTH(MAX_ROWS)) u_sums (
    .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(acc_nxt),
    .raddr_a(s_sum_raddr_a), .raddr_b(s_sum_raddr_b),
    .rdata_a_r(sum_rdata_a), .rdata_b_r(sum_rdata_b)
  );

  rsms_mem #(.DW(ROW_W), .DEPTH(2 * MAX_ROWS)) u_order (
    .clk(clk), .we(s_ord_we), .waddr(s_ord_waddr), .wdata(s_ord_wdata),
    .raddr_a(ord_raddr_a), .raddr_b(s_ord_raddr_b),
    .rdata_a_r(ord_rdata_a), .rdata_b_r(ord_rdata_b)
  );

  rsms_sort #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_sort (
    .clk(clk), .rst_n(rst_n), .start(sort_start), .n(row_cnt_nxt), .cols(eff),
    .stat(sort_stat),
    .ord_we(s_ord_we), .ord_waddr(s_ord_waddr), .ord_wdata(s_ord_wdata),
    .ord_raddr_a(s_ord_raddr_a), .ord_raddr_b(s_ord_raddr_b),
    .ord_rdata_a(ord_rdata_a), .ord_rdata_b(ord_rdata_b),
    .sum_raddr_a(s_sum_raddr_a), .sum_raddr_b(s_sum_raddr_b),
    .sum_rdata_a(sum_rdata_a), .sum_rdata_b(sum_rdata_b),
    .elem_raddr_a(s_elem_raddr_a), .elem_raddr_b(s_elem_raddr_b),
    .elem_rdata_a(elem_rdata_a), .elem_rdata_b(elem_rdata_b)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cols_r      <= CFG_W'(1);
      row_cnt_r   <= '0;
      col_cnt_r   <= '0;
      pos_r       <= '0;
      rd_row_r    <= '0;
      rd_col_r    <= '0;
      sorted_r    <= 1'b0;
      ovf_r       <= 1'b0;
      bank_r      <= 1'b0;
      recalc_r    <= 1'b0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cols_r      <= cols_nxt;
      row_cnt_r   <= row_cnt_nxt;
      col_cnt_r   <= col_cnt_nxt;
      pos_r       <= pos_nxt;
      rd_row_r    <= rd_row_nxt;
      rd_col_r    <= rd_col_nxt;
      sorted_r    <= sorted_nxt;
      ovf_r       <= ovf_nxt;
      bank_r      <= bank_nxt;
      recalc_r    <= recalc_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    fetch_row_r <= fetch_row_nxt;
    out_data_r  <= out_data_nxt;
  end

  // next state and outputs
  always_comb begin
    st_nxt        = st_r;
    row_cnt_nxt   = row_cnt_r;
    col_cnt_nxt   = col_cnt_r;
    pos_nxt       = pos_r;
    rd_row_nxt    = rd_row_r;
    rd_col_nxt    = rd_col_r;
    sorted_nxt    = sorted_r;
    ovf_nxt       = ovf_r;
    bank_nxt      = bank_r;
    recalc_nxt    = recalc_r || cfg_wr;
    div_cnt_nxt   = div_cnt_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    fetch_row_nxt = fetch_row_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    elem_we       = 1'b0;
    elem_waddr    = '0;
    elem_wdata    = '0;
    sum_we        = 1'b0;
    sum_waddr     = '0;
    sort_start    = 1'b0;
    rc0           = '0;
    rc1           = '0;
    cc0           = '0;
    cc1           = '0;
    cc2           = '0;
    ovf1          = 1'b0;
    sum_new       = '0;
    case (st_r)
      ST_IDLE: begin
        if (accept && in_data.mode == MODE_LOAD) begin
          // a load after a sorted set opens a new set
          rc0  = sorted_r ? '0 : row_cnt_r;
          cc0  = sorted_r ? '0 : col_cnt_r;
          ovf1 = sorted_r ? 1'b0 : ovf_r;
          sorted_nxt = 1'b0;
          pos_nxt    = '0;
          cc1 = (cc0 >= eff) ? '0 : cc0;
          cc2 = cc1 + 1'b1;
          rc1 = rc0;
          if (int'(rc0) < MAX_ROWS) begin
            sum_new    = (cc1 == '0) ? SUM_W'(v) : acc_r + SUM_W'(v);
            acc_nxt    = sum_new;
            elem_we    = 1'b1;
            elem_waddr = eaddr(int'(rc0), int'(cc1));
            elem_wdata = v;
            sum_we     = 1'b1;
            sum_waddr  = ROW_W'(rc0);
            if (cc2 >= eff) begin
              cc2 = '0;
              rc1 = rc0 + 1'b1;
            end
          end else begin
            ovf1 = 1'b1;
            if (cc2 >= eff) begin
              cc2 = '0;
            end
          end
          ovf_nxt     = ovf1;
          row_cnt_nxt = rc1;
          col_cnt_nxt = cc2;
          if (in_data.last_load) begin
            if (cc2 != '0 && int'(rc1) < MAX_ROWS) begin
              st_nxt = ST_FILL;
            end else begin
              col_cnt_nxt = '0;
              sort_start  = 1'b1;
              rd_row_nxt  = '0;
              rd_col_nxt  = '0;
              recalc_nxt  = 1'b0;
              st_nxt      = ST_SORT;
            end
          end
        end else if (accept) begin
          // fetch: nothing before sorting or past the end
          if (sorted_r && pos_r < total) begin
            if (recalc_r) begin
              quo_nxt     = pos_r;
              rem_nxt     = '0;
              div_cnt_nxt = DC_W'(POS_W);
              st_nxt      = ST_DIV;
            end else begin
              st_nxt = ST_FORD;
            end
          end
        end
      end
      // zero the rest of a partial last row
      ST_FILL: begin
        elem_we     = 1'b1;
        elem_waddr  = eaddr(int'(row_cnt_r), int'(col_cnt_r));
        elem_wdata  = '0;
        col_cnt_nxt = col_cnt_r + 1'b1;
        if (col_cnt_nxt >= eff) begin
          col_cnt_nxt = '0;
          row_cnt_nxt = row_cnt_r + 1'b1;
          sort_start  = 1'b1;
          rd_row_nxt  = '0;
          rd_col_nxt  = '0;
          recalc_nxt  = 1'b0;
          st_nxt      = ST_SORT;
        end
      end
      ST_SORT: begin
        if (sort_stat.done) begin
          sorted_nxt = 1'b1;
          bank_nxt   = sort_stat.bank;
          st_nxt     = ST_IDLE;
        end
      end
      // restoring divide of the position by the row length
      ST_DIV: begin
        if (rem_sh >= {1'b0, eff}) begin
          rem_nxt = rem_sh - {1'b0, eff};
          quo_nxt = {quo_r[POS_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[POS_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == DC_W'(1)) begin
          rd_row_nxt = RC_W'(quo_nxt);
          rd_col_nxt = EC_W'(rem_nxt);
          recalc_nxt = 1'b0;
          st_nxt     = ST_FORD;
        end
      end
      ST_FORD: begin
        st_nxt = ST_FIDX;
      end
      ST_FIDX: begin
        fetch_row_nxt = ord_rdata_a;
        st_nxt        = ST_FELEM;
      end
      ST_FELEM: begin
        st_nxt = ST_FOUT;
      end
      // hand the element to the output register once it is free
      ST_FOUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.value_res = elem_rdata_a;
          out_data_nxt.row_end   = (rd_col_r == eff - 1'b1);
          out_data_nxt.all_done  = (pos_r == total - 1'b1);
          out_data_nxt.dropped   = ovf_r;
          pos_nxt                = pos_r + 1'b1;
          if (rd_col_r == eff - 1'b1) begin
            rd_col_nxt = '0;
            rd_row_nxt = rd_row_r + 1'b1;
          end else begin
            rd_col_nxt = rd_col_r + 1'b1;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // checks
  `RSMS_ASSERT_NXT(a_last_starts_sort, accept && in_data.mode == MODE_LOAD && in_data.last_load, st_r == ST_FILL || st_r == ST_SORT, "last load did not start fill or sort")
  `RSMS_ASSERT_IMP(a_sort_unsorted, st_r == ST_SORT, !sorted_r, "sorted flag set while sorting")
  `RSMS_ASSERT_IMP(a_rows_bound, 1'b1, int'(row_cnt_r) <= MAX_ROWS, "row count beyond capacity")
  `RSMS_ASSERT_IMP(a_out_from_fetch, $rose(out_valid_r), $past(st_r) == ST_FOUT, "result without fetch")
  `RSMS_ASSERT_IMP(a_done_in_sort, sort_stat.done, st_r == ST_SORT, "sort done outside sort")

endmodule
